// ===== rtl/dwvc_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, item and register types, command/status structs for the
// differential wheel velocity controller. No dependencies.
package dwvc_pkg;

  localparam int SPD_W      = 18;
  localparam int CURV_W     = 16;
  localparam int DT_W       = 20;
  localparam int GAIN_W     = 32;
  localparam int STEP_W     = 17;
  localparam int TW_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier: gains, speed or v*c on A, speeds/diffs/curvature/track on B
  localparam int MUL_A_W = GAIN_W + 3;
  localparam int MUL_B_W = SPD_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int SPLIT_SHIFT = 21;
  localparam int PWR_SHIFT   = 16;

  // divider: |gain_accel * target change| < 2^50
  localparam int NUM_W    = GAIN_W + SPD_W;
  localparam int DIV_BITS = 2;

  localparam int SPD_MAX = (1 << (SPD_W - 1)) - 1;
  localparam int SPD_MIN = -(1 << (SPD_W - 1));

  localparam logic [GAIN_W-1:0] GAIN_VELOCITY_RST = GAIN_W'(6554);
  localparam logic [GAIN_W-1:0] GAIN_ACCEL_RST    = GAIN_W'(131);
  localparam logic [GAIN_W-1:0] GAIN_ERROR_RST    = GAIN_W'(655);
  localparam logic [STEP_W-1:0] MAX_STEP_RST      = STEP_W'(2560);
  localparam logic [TW_W-1:0]   TRACK_WIDTH_RST   = TW_W'(3584);

  typedef logic signed [SPD_W-1:0]  spd_t;
  typedef logic signed [CURV_W-1:0] curv_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_VELOCITY = CFG_IDX_W'(0),
    REG_GAIN_ACCEL    = CFG_IDX_W'(1),
    REG_GAIN_ERROR    = CFG_IDX_W'(2),
    REG_MAX_STEP      = CFG_IDX_W'(3),
    REG_TRACK_WIDTH   = CFG_IDX_W'(4)
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_velocity;
    logic [GAIN_W-1:0] gain_accel;
    logic [GAIN_W-1:0] gain_error;
    logic [STEP_W-1:0] max_step;
    logic [TW_W-1:0]   track_width;
  } cfg_t;

  typedef struct packed {
    spd_t            target_speed;
    curv_t           path_curvature;
    logic [DT_W-1:0] elapsed_us;
    spd_t            measured_left;
    spd_t            measured_right;
  } in_item_t;

  typedef struct packed {
    spd_t left_power;
    spd_t right_power;
    spd_t left_limited;
    spd_t right_limited;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul_vc;
    logic mul_tw;
    logic target;
    logic slew;
    logic mul_acc;
    logic div_start;
    logic mul_vel;
    logic mul_err;
    logic sum;
    logic store;
    logic finish;
    logic wheel;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic div_done;
  } sts_t;

  function automatic spd_t sat_spd(input prod_t x);
    spd_t r;
    if (x > PROD_W'(SPD_MAX)) begin
      r = spd_t'(SPD_MAX);
    end else if (x < PROD_W'(SPD_MIN)) begin
      r = spd_t'(SPD_MIN);
    end else begin
      r = x[SPD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dwvc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on dwvc_pkg.
interface dwvc_in_if;
  logic                         valid;
  logic                         ready;
  dwvc_pkg::spd_t               target_speed;
  dwvc_pkg::curv_t              path_curvature;
  logic [dwvc_pkg::DT_W-1:0]    elapsed_us;
  dwvc_pkg::spd_t               measured_left;
  dwvc_pkg::spd_t               measured_right;

  modport source (output valid, target_speed, path_curvature, elapsed_us,
                  measured_left, measured_right, input ready);
  modport sink   (input valid, target_speed, path_curvature, elapsed_us,
                  measured_left, measured_right, output ready);
endinterface

interface dwvc_out_if;
  logic           valid;
  logic           ready;
  dwvc_pkg::spd_t left_power;
  dwvc_pkg::spd_t right_power;
  dwvc_pkg::spd_t left_limited;
  dwvc_pkg::spd_t right_limited;

  modport source (output valid, left_power, right_power, left_limited,
                  right_limited, input ready);
  modport sink   (input valid, left_power, right_power, left_limited,
                  right_limited, output ready);
endinterface

interface dwvc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dwvc_pkg::CFG_IDX_W-1:0]  index;
  logic [dwvc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dwvc_div.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, DIV_BITS quotient bits per cycle.
// Depends on dwvc_pkg.
module dwvc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dwvc_pkg::NUM_W-1:0]  num_i,
  input  logic [dwvc_pkg::DT_W-1:0]   den_i,
  output logic                        done_o,
  output logic [dwvc_pkg::NUM_W-1:0]  quo_o
);
  import dwvc_pkg::*;

  localparam int DIV_CYCLES = NUM_W / DIV_BITS;
  localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DT_W-1:0]  rem_q, rem_d;
  logic [DT_W-1:0]  den_q;

  always_comb begin
    logic [NUM_W-1:0] n;
    logic [DT_W-1:0]  r;
    logic [DT_W:0]    t;
    n = num_q;
    r = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, n[NUM_W-1]};
      n = {n[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t    = t - {1'b0, den_q};
        n[0] = 1'b1;
      end
      r = t[DT_W-1:0];
    end
    num_d  = n;
    rem_d  = r;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_CYCLES);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== rtl/dwvc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: input registers, shared multiplier, wheel split, slew limit,
// power accumulation, wheel state and result registers. Depends on dwvc_pkg, dwvc_div.
module dwvc_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dwvc_pkg::cmd_t       cmd_i,
  output dwvc_pkg::sts_t       sts_o,
  input  dwvc_pkg::cfg_t       cfg_i,
  input  dwvc_pkg::in_item_t   item_i,
  output dwvc_pkg::out_item_t  item_o
);
  import dwvc_pkg::*;

  spd_t             v_q, ml_q, mr_q;
  curv_t            c_q;
  logic [DT_W-1:0]  dt_q;
  prod_t            p_q, acc_q;
  spd_t             lt_q, rt_q, ll_q, rl_q, pl_q, pr_q;
  spd_t             out_pl_q, out_pr_q;
  spd_t             prev_lt_q, prev_rt_q, last_ll_q, last_rl_q;
  logic             neg_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  prod_t                     prod;
  spd_t                      tgt_w, prev_w, lim_w, meas_w;
  logic signed [SPD_W:0]     tgt_diff, err_diff;
  prod_t                     split_d, v_ext, num_abs, q_ext, acc_div;
  spd_t                      lt_n, rt_n, pwr_n;
  logic                      div_done;
  logic [NUM_W-1:0]          quo;

  function automatic spd_t slew(input spd_t tgt, input spd_t last,
                                input logic [STEP_W-1:0] step);
    logic signed [SPD_W:0] diff;
    logic [SPD_W:0]        mag;
    logic [SPD_W:0]        res;
    diff = {tgt[SPD_W-1], tgt} - {last[SPD_W-1], last};
    mag  = diff[SPD_W] ? -diff : diff;
    if (mag > {{(SPD_W + 1 - STEP_W){1'b0}}, step}) begin
      mag = {{(SPD_W + 1 - STEP_W){1'b0}}, step};
    end
    res = diff[SPD_W] ? {last[SPD_W-1], last} - mag : {last[SPD_W-1], last} + mag;
    return res[SPD_W-1:0];
  endfunction

  assign tgt_w  = cmd_i.wheel ? rt_q : lt_q;
  assign prev_w = cmd_i.wheel ? prev_rt_q : prev_lt_q;
  assign lim_w  = cmd_i.wheel ? rl_q : ll_q;
  assign meas_w = cmd_i.wheel ? mr_q : ml_q;

  assign tgt_diff = {tgt_w[SPD_W-1], tgt_w} - {prev_w[SPD_W-1], prev_w};
  assign err_diff = {lim_w[SPD_W-1], lim_w} - {meas_w[SPD_W-1], meas_w};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (cmd_i.mul_vc) begin
      mul_a = {{(MUL_A_W - SPD_W){v_q[SPD_W-1]}}, v_q};
      mul_b = {{(MUL_B_W - CURV_W){c_q[CURV_W-1]}}, c_q};
    end else if (cmd_i.mul_tw) begin
      mul_a = p_q[MUL_A_W-1:0];
      mul_b = {{(MUL_B_W - TW_W){1'b0}}, cfg_i.track_width};
    end else if (cmd_i.mul_acc) begin
      mul_a = {{(MUL_A_W - GAIN_W){1'b0}}, cfg_i.gain_accel};
      mul_b = tgt_diff;
    end else if (cmd_i.mul_vel) begin
      mul_a = {{(MUL_A_W - GAIN_W){1'b0}}, cfg_i.gain_velocity};
      mul_b = {lim_w[SPD_W-1], lim_w};
    end else if (cmd_i.mul_err) begin
      mul_a = {{(MUL_A_W - GAIN_W){1'b0}}, cfg_i.gain_error};
      mul_b = err_diff;
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
  end

  assign prod = mul_a * mul_b;

  assign split_d = p_q >>> SPLIT_SHIFT;
  assign v_ext   = {{(PROD_W - SPD_W){v_q[SPD_W-1]}}, v_q};
  assign lt_n    = sat_spd(v_ext + split_d);
  assign rt_n    = sat_spd(v_ext - split_d);

  assign num_abs = p_q[PROD_W-1] ? -p_q : p_q;
  assign q_ext   = {{(PROD_W - NUM_W){1'b0}}, quo};
  assign acc_div = neg_q ? -q_ext : q_ext;
  assign pwr_n   = sat_spd(acc_q >>> PWR_SHIFT);

  dwvc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_abs[NUM_W-1:0]),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q  <= item_i.target_speed;
      c_q  <= item_i.path_curvature;
      dt_q <= item_i.elapsed_us;
      ml_q <= item_i.measured_left;
      mr_q <= item_i.measured_right;
    end
    if (cmd_i.mul_vc || cmd_i.mul_tw || cmd_i.mul_acc || cmd_i.mul_vel ||
        cmd_i.mul_err) begin
      p_q <= prod;
    end
    if (cmd_i.target) begin
      lt_q <= lt_n;
      rt_q <= rt_n;
    end
    if (cmd_i.slew) begin
      ll_q <= slew(lt_q, last_ll_q, cfg_i.max_step);
      rl_q <= slew(rt_q, last_rl_q, cfg_i.max_step);
    end
    if (cmd_i.div_start) begin
      neg_q <= p_q[PROD_W-1];
    end
    if (cmd_i.mul_vel) begin
      acc_q <= (dt_q == '0) ? '0 : acc_div;
    end else if (cmd_i.mul_err || cmd_i.sum) begin
      acc_q <= acc_q + p_q;
    end
    if (cmd_i.store) begin
      if (cmd_i.wheel) begin
        pr_q <= pwr_n;
      end else begin
        pl_q <= pwr_n;
      end
    end
    if (cmd_i.finish) begin
      out_pl_q <= pl_q;
      out_pr_q <= pr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lt_q <= '0;
      prev_rt_q <= '0;
      last_ll_q <= '0;
      last_rl_q <= '0;
    end else if (cmd_i.finish) begin
      prev_lt_q <= lt_q;
      prev_rt_q <= rt_q;
      last_ll_q <= ll_q;
      last_rl_q <= rl_q;
    end
  end

  assign sts_o.dt_zero  = (dt_q == '0);
  assign sts_o.div_done = div_done;

  assign item_o.left_power    = out_pl_q;
  assign item_o.right_power   = out_pr_q;
  assign item_o.left_limited  = last_ll_q;
  assign item_o.right_limited = last_rl_q;

endmodule

// ===== rtl/dwvc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: steps the datapath through one item, left wheel then right,
// and owns the input ready and result valid. Depends on dwvc_pkg.
module dwvc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  dwvc_pkg::sts_t sts_i,
  output dwvc_pkg::cmd_t cmd_o
);
  import dwvc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_MUL_VC    = 13'b0000000000010,
    S_MUL_TW    = 13'b0000000000100,
    S_TARGET    = 13'b0000000001000,
    S_SLEW      = 13'b0000000010000,
    S_MUL_ACC   = 13'b0000000100000,
    S_DIV_START = 13'b0000001000000,
    S_DIV_WAIT  = 13'b0000010000000,
    S_MUL_VEL   = 13'b0000100000000,
    S_MUL_ERR   = 13'b0001000000000,
    S_SUM       = 13'b0010000000000,
    S_STORE     = 13'b0100000000000,
    S_FINISH    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   wheel_q, wheel_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    wheel_d     = wheel_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.wheel = wheel_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          wheel_d    = 1'b0;
          state_d    = S_MUL_VC;
        end
      end
      S_MUL_VC: begin
        cmd_o.mul_vc = 1'b1;
        state_d      = S_MUL_TW;
      end
      S_MUL_TW: begin
        cmd_o.mul_tw = 1'b1;
        state_d      = S_TARGET;
      end
      S_TARGET: begin
        cmd_o.target = 1'b1;
        state_d      = S_SLEW;
      end
      S_SLEW: begin
        cmd_o.slew = 1'b1;
        state_d    = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        cmd_o.mul_acc = 1'b1;
        state_d       = S_DIV_START;
      end
      S_DIV_START: begin
        if (sts_i.dt_zero) begin
          state_d = S_MUL_VEL;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_MUL_VEL;
        end
      end
      S_MUL_VEL: begin
        cmd_o.mul_vel = 1'b1;
        state_d       = S_MUL_ERR;
      end
      S_MUL_ERR: begin
        cmd_o.mul_err = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (wheel_q) begin
          state_d = S_FINISH;
        end else begin
          wheel_d = 1'b1;
          state_d = S_MUL_ACC;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wheel_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wheel_q     <= wheel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_no_div_on_zero_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV_WAIT |-> !sts_i.dt_zero)
    else $error("divider waited on with zero elapsed time");

  a_accept_starts_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_MUL_VC)
    else $error("accepted item did not start");

  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == S_DIV_WAIT)
    else $error("divider done outside wait state");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH && out_valid_q && !out_ready_i
      |=> state_q == S_FINISH && out_valid_q)
    else $error("finished item overwrote pending result");

endmodule

// ===== rtl/differential_wheel_velocity_control_core.sv =====
`timescale 1ns / 1ps
// Top level: register file, sequencer and datapath of the wheel velocity
// controller. Depends on dwvc_pkg, dwvc_if, dwvc_ctrl, dwvc_datapath.

// One item is one control tick. The block takes an item only when idle. It
// first splits and slew-limits both wheels, then works through each wheel in
// turn, waiting on the shared 2-bit-per-cycle divider that forms the
// acceleration term, and last hands the result to the output register once
// that register is free. With an elapsed time of zero the divider is skipped.
// A finished result waits in the output register, so the next item can be
// taken and worked on before the last one is collected. Register writes are
// always ready; indexes beyond the register list are ignored.
module differential_wheel_velocity_control_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  dwvc_in_if.sink    in_i,
  dwvc_out_if.source out_o,
  dwvc_cfg_if.sink   cfg_i
);
  import dwvc_pkg::*;

  cfg_t      cfg_q;
  cmd_t      cmd;
  sts_t      sts;
  in_item_t  in_item;
  out_item_t out_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_velocity <= GAIN_VELOCITY_RST;
      cfg_q.gain_accel    <= GAIN_ACCEL_RST;
      cfg_q.gain_error    <= GAIN_ERROR_RST;
      cfg_q.max_step      <= MAX_STEP_RST;
      cfg_q.track_width   <= TRACK_WIDTH_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_GAIN_VELOCITY: cfg_q.gain_velocity <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_ACCEL:    cfg_q.gain_accel    <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_ERROR:    cfg_q.gain_error    <= cfg_i.data[GAIN_W-1:0];
        REG_MAX_STEP:      cfg_q.max_step      <= cfg_i.data[STEP_W-1:0];
        REG_TRACK_WIDTH:   cfg_q.track_width   <= cfg_i.data[TW_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.target_speed   = in_i.target_speed;
  assign in_item.path_curvature = in_i.path_curvature;
  assign in_item.elapsed_us     = in_i.elapsed_us;
  assign in_item.measured_left  = in_i.measured_left;
  assign in_item.measured_right = in_i.measured_right;

  dwvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dwvc_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .cfg_i  (cfg_q),
    .item_i (in_item),
    .item_o (out_item)
  );

  assign out_o.left_power    = out_item.left_power;
  assign out_o.right_power   = out_item.right_power;
  assign out_o.left_limited  = out_item.left_limited;
  assign out_o.right_limited = out_item.right_limited;

endmodule
